[rtl/igms_pkg.sv]
// Package for the IR-gated motor sequencer: payload and config types,
// mode, drive and register codes, coil patterns, and the IR scaling function.
// No dependencies.
package igms_pkg;

    // Sensor window depth (scaled samples kept for the beam test)
    localparam int WINDOW_DEPTH = 3;

    // Item kinds
    localparam logic OP_SAMPLE = 1'b0;
    localparam logic OP_TICK   = 1'b1;

    // Mode codes
    localparam logic [1:0] MODE_IDLE  = 2'd0;
    localparam logic [1:0] MODE_PUSH  = 2'd1;
    localparam logic [1:0] MODE_TIMED = 2'd2;

    // DC motor drive codes
    localparam logic [1:0] DC_STOP    = 2'd0;
    localparam logic [1:0] DC_FORWARD = 2'd1;
    localparam logic [1:0] DC_REVERSE = 2'd2;

    // Coils released
    localparam logic [3:0] COIL_OFF = 4'h0;

    // Configuration register indexes
    localparam logic [2:0] CFG_IR_THRESHOLD  = 3'd0;
    localparam logic [2:0] CFG_PUSH_START    = 3'd1;
    localparam logic [2:0] CFG_PUSH_STOP     = 3'd2;
    localparam logic [2:0] CFG_REVERSE_START = 3'd3;
    localparam logic [2:0] CFG_REVERSE_STOP  = 3'd4;
    localparam logic [2:0] CFG_PULL_BEGIN    = 3'd5;
    localparam logic [2:0] CFG_PULL_END      = 3'd6;
    localparam logic [2:0] CFG_FINISH        = 3'd7;

    // Configuration reset values
    localparam logic [7:0]  RST_IR_THRESHOLD  = 8'd30;
    localparam logic [11:0] RST_PUSH_START    = 12'd600;
    localparam logic [11:0] RST_PUSH_STOP     = 12'd850;
    localparam logic [11:0] RST_REVERSE_START = 12'd870;
    localparam logic [11:0] RST_REVERSE_STOP  = 12'd1118;
    localparam logic [11:0] RST_PULL_BEGIN    = 12'd845;
    localparam logic [11:0] RST_PULL_END      = 12'd1090;
    localparam logic [11:0] RST_FINISH        = 12'd1120;

    // Stepper patterns by phase
    localparam logic [3:0] FWD_PATTERN [4] = '{4'hC, 4'h6, 4'h3, 4'h9};
    localparam logic [3:0] REV_PATTERN [4] = '{4'h9, 4'h3, 4'h6, 4'hC};

    // IR scaling: floor(raw * SCALE_NUM / SCALE_DEN)
    localparam logic [17:0] SCALE_NUM = 18'd198;
    localparam logic [10:0] SCALE_DEN = 11'd1023;

    typedef struct packed {
        logic       opcode;
        logic [9:0] adc_sample;
    } t_in_item;

    typedef struct packed {
        logic [3:0] coil_drive;
        logic [1:0] dc_drive;
        logic [1:0] mode;
    } t_out_item;

    typedef struct packed {
        logic [7:0]  ir_threshold;
        logic [11:0] push_start_tick;
        logic [11:0] push_stop_tick;
        logic [11:0] reverse_start_tick;
        logic [11:0] reverse_stop_tick;
        logic [11:0] pull_begin_tick;
        logic [11:0] pull_end_tick;
        logic [11:0] finish_tick;
    } t_cfg;

    // Divide by 1023 as x/1024 plus one correction step: the remainder
    // (x mod 1024) + q0 stays below twice the divisor.
    function automatic logic [7:0] scale_sample(input logic [9:0] raw);
        logic [17:0] prod;
        logic [7:0]  q0;
        logic [10:0] rem;
        prod = {8'd0, raw} * SCALE_NUM;
        q0   = prod[17:10];
        rem  = {1'b0, prod[9:0]} + {3'd0, q0};
        if (rem >= SCALE_DEN) begin
            q0 = q0 + 8'd1;
        end
        return q0;
    endfunction

endpackage

[rtl/igms_core.sv]
// Sequencer state and next-state logic for the IR-gated motor sequencer.
// Depends on igms_pkg (types, codes, patterns, scaling function).
module igms_core import igms_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_fire,
    input  t_in_item  i_item,
    input  t_cfg      i_cfg,
    output t_out_item o_result
);

    logic [7:0]  r_ir_window [WINDOW_DEPTH];
    logic [7:0]  n_ir_window [WINDOW_DEPTH];
    logic [1:0]  r_mode, n_mode;
    logic [1:0]  r_phase, n_phase;
    logic [11:0] r_tick_count, n_tick_count;
    logic [3:0]  r_coil, n_coil;
    logic [1:0]  r_dc, n_dc;
    logic        all_above;
    logic        any_above;

    // Shift the scaled sample into the window
    always_comb begin
        for (int k = 0; k < WINDOW_DEPTH - 1; k++) begin
            n_ir_window[k] = r_ir_window[k + 1];
        end
        n_ir_window[WINDOW_DEPTH - 1] = scale_sample(i_item.adc_sample);
    end

    // Beam test over the updated window
    always_comb begin
        all_above = 1'b1;
        any_above = 1'b0;
        for (int k = 0; k < WINDOW_DEPTH; k++) begin
            if (n_ir_window[k] > i_cfg.ir_threshold) begin
                any_above = 1'b1;
            end else begin
                all_above = 1'b0;
            end
        end
    end

    // Next state for one request
    always_comb begin
        n_mode       = r_mode;
        n_phase      = r_phase;
        n_tick_count = r_tick_count;
        n_coil       = r_coil;
        n_dc         = r_dc;
        if (i_item.opcode == OP_SAMPLE) begin
            if (n_mode == MODE_IDLE && all_above) begin
                n_mode = MODE_PUSH;
            end
            if (n_mode == MODE_PUSH) begin
                if (any_above) begin
                    n_coil = FWD_PATTERN[r_phase];
                end else begin
                    n_mode       = MODE_TIMED;
                    n_tick_count = '0;
                end
            end
            if (n_mode == MODE_TIMED) begin
                if (n_tick_count == '0) begin
                    n_coil = COIL_OFF;
                end
                if (n_tick_count == i_cfg.push_start_tick) begin
                    n_dc = DC_FORWARD;
                end
                if (n_tick_count == i_cfg.push_stop_tick) begin
                    n_dc = DC_STOP;
                end
                if (n_tick_count == i_cfg.reverse_start_tick) begin
                    n_dc = DC_REVERSE;
                end
                if (n_tick_count == i_cfg.reverse_stop_tick) begin
                    n_dc = DC_STOP;
                end
                if (n_tick_count < i_cfg.pull_end_tick &&
                    n_tick_count >= i_cfg.pull_begin_tick) begin
                    n_coil = REV_PATTERN[r_phase];
                end
                if (n_tick_count == i_cfg.finish_tick) begin
                    n_mode       = MODE_IDLE;
                    n_tick_count = '0;
                end
            end
        end else if (r_mode != MODE_IDLE) begin
            n_phase      = r_phase + 2'd1;
            n_tick_count = r_tick_count + 12'd1;
        end
    end

    // Result reflects the state after the request
    assign o_result.coil_drive = n_coil;
    assign o_result.dc_drive   = n_dc;
    assign o_result.mode       = n_mode;

    // Hold or advance the state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < WINDOW_DEPTH; k++) begin
                r_ir_window[k] <= '0;
            end
            r_mode       <= MODE_IDLE;
            r_phase      <= '0;
            r_tick_count <= '0;
            r_coil       <= COIL_OFF;
            r_dc         <= DC_STOP;
        end else if (i_fire) begin
            if (i_item.opcode == OP_SAMPLE) begin
                r_ir_window <= n_ir_window;
            end
            r_mode       <= n_mode;
            r_phase      <= n_phase;
            r_tick_count <= n_tick_count;
            r_coil       <= n_coil;
            r_dc         <= n_dc;
        end
    end

`ifndef SYNTH
    // Timed mode always starts at tick zero
    a_timed_entry: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_mode == MODE_TIMED && $past(r_mode) != MODE_TIMED) |-> r_tick_count == '0)
        else $error("timed mode entered with nonzero tick count");

    // Ticks in idle leave the timer alone
    a_idle_tick: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_fire && i_item.opcode == OP_TICK && r_mode == MODE_IDLE)
        |=> ($stable(r_tick_count) && $stable(r_phase) && r_mode == MODE_IDLE))
        else $error("tick changed timer state while idle");

    // From idle only push can follow
    a_idle_exit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_fire && r_mode == MODE_IDLE) |=> (r_mode == MODE_IDLE || r_mode == MODE_PUSH))
        else $error("idle left for a mode other than push");

    // No state change without a request
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_fire |=> ($stable(r_mode) && $stable(r_tick_count) && $stable(r_coil)
                     && $stable(r_dc)))
        else $error("state changed without a request");
`endif

endmodule

[rtl/ir_gated_motor_sequencer.sv]
// Top level of the IR-gated motor sequencer: config registers, sequencer
// core and a two-entry result buffer. Depends on igms_pkg and igms_core.
//
//  channel  | direction | handshake                    | payload
//  ---------+-----------+------------------------------+---------------------------
//  in       | input     | i_in_valid / o_in_ready      | i_in_item  (t_in_item)
//  out      | output    | o_out_valid / i_out_ready    | o_out_item (t_out_item)
//  cfg      | input     | i_cfg_valid / o_cfg_ready    | i_cfg_index, i_cfg_data
//
// One request per cycle while o_in_ready is high; each result is registered for the out channel.
// The result path is an output register plus a skid register, so a new
// request is taken while one result waits; o_in_ready drops only when both hold.
// Synchronous active-low reset clears the state, loads the config defaults
// and empties the result buffer. Config writes are always accepted.
module ir_gated_motor_sequencer import igms_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_ready,
    input  t_in_item  i_in_item,
    output logic      o_out_valid,
    input  logic      i_out_ready,
    output t_out_item o_out_item,
    input  logic      i_cfg_valid,
    output logic      o_cfg_ready,
    input  logic [2:0] i_cfg_index,
    input  logic [11:0] i_cfg_data
);

    t_cfg      r_cfg;
    t_out_item core_result;
    t_out_item r_out, r_skid;
    logic      r_out_valid, r_skid_valid;
    logic      in_fire, out_fire;

    assign o_cfg_ready = 1'b1;
    assign o_in_ready  = !r_skid_valid;
    assign in_fire     = i_in_valid && o_in_ready;
    assign out_fire    = r_out_valid && i_out_ready;
    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;

    // Config register writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.ir_threshold       <= RST_IR_THRESHOLD;
            r_cfg.push_start_tick    <= RST_PUSH_START;
            r_cfg.push_stop_tick     <= RST_PUSH_STOP;
            r_cfg.reverse_start_tick <= RST_REVERSE_START;
            r_cfg.reverse_stop_tick  <= RST_REVERSE_STOP;
            r_cfg.pull_begin_tick    <= RST_PULL_BEGIN;
            r_cfg.pull_end_tick      <= RST_PULL_END;
            r_cfg.finish_tick        <= RST_FINISH;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_IR_THRESHOLD:  r_cfg.ir_threshold       <= i_cfg_data[7:0];
                CFG_PUSH_START:    r_cfg.push_start_tick    <= i_cfg_data;
                CFG_PUSH_STOP:     r_cfg.push_stop_tick     <= i_cfg_data;
                CFG_REVERSE_START: r_cfg.reverse_start_tick <= i_cfg_data;
                CFG_REVERSE_STOP:  r_cfg.reverse_stop_tick  <= i_cfg_data;
                CFG_PULL_BEGIN:    r_cfg.pull_begin_tick    <= i_cfg_data;
                CFG_PULL_END:      r_cfg.pull_end_tick      <= i_cfg_data;
                CFG_FINISH:        r_cfg.finish_tick        <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    // Sequencer state and next-state logic
    igms_core u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_fire   (in_fire),
        .i_item   (i_in_item),
        .i_cfg    (r_cfg),
        .o_result (core_result)
    );

    // Result buffer control: output register with skid behind it
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (in_fire) begin
            if (!r_out_valid || out_fire) begin
                r_out_valid <= 1'b1;
            end else begin
                r_skid_valid <= 1'b1;
            end
        end else if (out_fire) begin
            r_out_valid  <= r_skid_valid;
            r_skid_valid <= 1'b0;
        end
    end

    // Result buffer payload
    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            if (!r_out_valid || out_fire) begin
                r_out <= core_result;
            end else begin
                r_skid <= core_result;
            end
        end else if (out_fire && r_skid_valid) begin
            r_out <= r_skid;
        end
    end

endmodule
